// ===== rtl/core/sack_pkg.sv =====
// ----------------------------------------------------------------------------
// SACK reorder tracker package
// Shared packet-kind codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package sack_pkg;

  localparam logic [1:0] FUNC_DATA = 2'd0;
  localparam logic [1:0] FUNC_FIN  = 2'd1;

  typedef struct packed {
    logic load;       // latch input transaction
    logic fin_take;   // record FIN if first
    logic mark;       // set bit of loaded sequence
    logic drop;       // flag loaded sequence as beyond the window
    logic shift;      // release bit 0, advance expected sequence
    logic scan_start; // reset range scanner
    logic scan_step;  // examine next bitmap position
    logic open_rng;   // begin a range at scan position
    logic close_rng;  // finish the open range
    logic emit;       // load output register from current result
    logic emit_fin;   // emit is a FIN acknowledgement
    logic emit_last;  // emitted result is the final one
  } sack_cmd_t;

  typedef struct packed {
    logic is_fin;
    logic is_data;
    logic fin_seen;
    logic in_window;
    logic old_seq;
    logic bit0;
    logic scan_bit;
    logic scan_end;
    logic rng_open;
    logic blocks_full;
    logic emit_final;
    logic out_busy;
  } sack_sts_t;

endpackage

// ===== rtl/core/sack_datapath.sv =====
// ----------------------------------------------------------------------------
// SACK reorder tracker datapath
// Held bitmap, expected sequence, range scanner and output register.
// ----------------------------------------------------------------------------
module sack_datapath import sack_pkg::*; #(
  parameter int WINDOW     = 64,
  parameter int MAX_BLOCKS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_seq,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  sack_cmd_t   cmd,
  output sack_sts_t   sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] o_cum_ack,
  output logic [15:0] o_avail,
  output logic [4:0]  o_bcount,
  output logic        o_bvalid,
  output logic [31:0] o_bstart,
  output logic [31:0] o_bend,
  output logic [6:0]  o_released,
  output logic        o_dropped,
  output logic        o_is_fin,
  output logic [31:0] o_fin_ack,
  output logic        o_last
);

  localparam int IW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int BW = $clog2(MAX_BLOCKS + 1);
  localparam int KW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [15:0]       win_r;
  logic [31:0]       exp_r;
  logic [WINDOW-1:0] map_r;
  logic [CW-1:0]     held_r;
  logic              fin_seen_r;
  logic [31:0]       fin_seq_r;
  logic [1:0]        func_r;
  logic [31:0]       seq_r;
  logic [6:0]        rel_r;
  logic              drop_r;
  logic [IW:0]       pos_r;
  logic              open_r;
  logic [IW-1:0]     rstart_r;
  logic [BW-1:0]     nb_r;
  logic [BW-1:0]     eidx_r;
  logic [IW-1:0]     rs_r [MAX_BLOCKS];
  logic [IW-1:0]     re_r [MAX_BLOCKS];
  logic              ov_r;

  logic [31:0] diff;
  logic [IW-1:0] pos_i;
  logic [15:0] avail;
  logic [16:0] wsub;
  logic [KW-1:0] wr_k;
  logic [KW-1:0] sel_k;

  assign diff  = seq_r - exp_r;
  assign pos_i = pos_r[IW-1:0];
  assign wsub  = {1'b0, win_r} - 17'(held_r);
  assign avail = (wsub[16] || wsub[15:0] <= 16'd1) ? 16'd1 : wsub[15:0];
  assign wr_k  = nb_r[KW-1:0];
  assign sel_k = eidx_r[KW-1:0];

  always_comb begin
    sts.is_fin      = (func_r == FUNC_FIN);
    sts.is_data     = (func_r == FUNC_DATA);
    sts.fin_seen    = fin_seen_r;
    sts.old_seq     = seq_r < exp_r;
    sts.in_window   = diff < 32'(WINDOW);
    sts.bit0        = map_r[0];
    sts.scan_bit    = map_r[pos_i];
    sts.scan_end    = pos_r == (IW+1)'(WINDOW);
    sts.rng_open    = open_r;
    sts.blocks_full = nb_r == BW'(MAX_BLOCKS);
    sts.emit_final  = (nb_r == '0) || (BW'(eidx_r + 1'b1) == nb_r);
    sts.out_busy    = ov_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 16'd64; exp_r <= 32'd1; map_r <= '0; held_r <= '0;
      fin_seen_r <= 1'b0; fin_seq_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cfg_we) win_r <= cfg_wdata;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (cmd.fin_take && !fin_seen_r) begin
        fin_seen_r <= 1'b1; fin_seq_r <= seq_r;
      end
      if (cmd.mark && !map_r[diff[IW-1:0]]) begin
        map_r[diff[IW-1:0]] <= 1'b1;
        held_r <= held_r + 1'b1;
      end
      if (cmd.shift) begin
        map_r  <= map_r >> 1;
        held_r <= held_r - 1'b1;
        exp_r  <= exp_r + 32'd1;
      end
      if (cmd.emit) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func; seq_r <= in_seq; rel_r <= '0; drop_r <= 1'b0;
    end
    if (cmd.drop) drop_r <= 1'b1;
    if (cmd.shift && rel_r != 7'd127) rel_r <= rel_r + 7'd1;
    if (cmd.scan_start) begin
      pos_r <= (IW+1)'(1); open_r <= 1'b0; nb_r <= '0; eidx_r <= '0;
    end
    if (cmd.scan_step) pos_r <= pos_r + 1'b1;
    if (cmd.open_rng) begin
      open_r <= 1'b1; rstart_r <= pos_i;
    end
    // keep range bounds as offsets from the expected sequence
    if (cmd.close_rng) begin
      open_r      <= 1'b0;
      nb_r        <= nb_r + 1'b1;
      rs_r[wr_k]  <= rstart_r;
      re_r[wr_k]  <= IW'(pos_r - 1'b1);
    end
    if (cmd.emit) begin
      o_cum_ack  <= exp_r - 32'd1;
      o_last     <= cmd.emit_last;
      o_is_fin   <= cmd.emit_fin;
      if (cmd.emit_fin) begin
        o_avail <= (win_r == 16'd0) ? 16'd1 : win_r;
        o_bcount <= '0; o_bvalid <= 1'b0; o_bstart <= '0; o_bend <= '0;
        o_released <= '0; o_dropped <= 1'b0;
        o_fin_ack <= (fin_seen_r ? fin_seq_r : seq_r) + 32'd1;
      end else begin
        o_avail    <= avail;
        o_bcount   <= 5'(nb_r);
        o_bvalid   <= nb_r != '0;
        o_bstart   <= (nb_r != '0) ? exp_r + 32'(rs_r[sel_k]) : 32'd0;
        o_bend     <= (nb_r != '0) ? exp_r + 32'(re_r[sel_k]) : 32'd0;
        o_released <= rel_r;
        o_dropped  <= drop_r;
        o_fin_ack  <= '0;
        eidx_r     <= eidx_r + 1'b1;
      end
    end
  end

  assign out_valid = ov_r;

endmodule

// ===== rtl/core/sack_ctrl.sv =====
// ----------------------------------------------------------------------------
// SACK reorder tracker controller
// Sequences mark, release, range scan and result emission.
// ----------------------------------------------------------------------------
module sack_ctrl import sack_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sack_sts_t sts,
  output sack_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_RELEASE, S_SCAN, S_EMIT} state_t;
  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1; state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_fin) begin
          if (!sts.out_busy) begin
            cmd.fin_take = 1'b1; cmd.emit = 1'b1; cmd.emit_fin = 1'b1;
            cmd.emit_last = 1'b1; state_nxt = S_IDLE;
          end
        end else if (!sts.is_data || sts.fin_seen) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.mark = !sts.old_seq && sts.in_window;
          cmd.drop = !sts.old_seq && !sts.in_window;
          state_nxt = S_RELEASE;
        end
      end
      S_RELEASE: begin
        if (sts.bit0) cmd.shift = 1'b1;
        else begin
          cmd.scan_start = 1'b1; state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.blocks_full) begin
          state_nxt = S_EMIT;
        end else if (sts.scan_end) begin
          if (sts.rng_open) cmd.close_rng = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          if (sts.rng_open && !sts.scan_bit) cmd.close_rng = 1'b1;
          if (!sts.rng_open && sts.scan_bit) cmd.open_rng = 1'b1;
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        // send stored ranges lowest first, or the single empty ack
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.emit_last = sts.emit_final;
          if (sts.emit_final) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/core/sack_receive_reorder_tracker.sv =====
// ----------------------------------------------------------------------------
// SACK receive reorder tracker
// Tracks in-order delivery and held out-of-order packets; emits SACK acks.
// ----------------------------------------------------------------------------
// One packet transaction at a time. A data transaction runs decode, release of
// each in-order packet, the range scan and one emitted beat per SACK range (one
// when there is none), plus output stalls; the range scan stops early once
// MAX_BLOCKS ranges are found. A FIN or an ignored transaction ends at decode,
// a FIN held there while the output register is still full. The held bitmap
// is walked one position per cycle by the range scanner.
module sack_receive_reorder_tracker import sack_pkg::*; #(
  parameter int WINDOW     = 64,
  parameter int MAX_BLOCKS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,      // recv_window
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_tuser,       // func
  input  logic [31:0]   in_tdata,       // seq
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic          out_tlast,
  output logic [159:0]  out_tdata       // cum_ack, avail_window, block_count,
                                        // block_valid, block_start, block_end,
                                        // released_count, dropped, is_fin_ack,
                                        // fin_ack, pad
);
  sack_cmd_t cmd;
  sack_sts_t sts;
  logic [31:0] cum, bs, be, fa;
  logic [15:0] av;
  logic [4:0]  bc;
  logic [6:0]  rel;
  logic        bv, dr, fi;

  sack_ctrl u_ctrl (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
                    .sts, .cmd);

  sack_datapath #(.WINDOW(WINDOW), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk, .rst_n, .in_func(in_tuser), .in_seq(in_tdata), .cfg_we, .cfg_wdata,
    .cmd, .sts, .out_valid(out_tvalid), .out_ready(out_tready),
    .o_cum_ack(cum), .o_avail(av), .o_bcount(bc), .o_bvalid(bv),
    .o_bstart(bs), .o_bend(be), .o_released(rel), .o_dropped(dr),
    .o_is_fin(fi), .o_fin_ack(fa), .o_last(out_tlast));

  assign out_tdata = {1'b0, fa, fi, dr, rel, be, bs, bv, bc, av, cum};

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accepted while busy");
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[126] |-> out_tlast) else $error("fin ack not last");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// SACK receive reorder tracker testbench
// Sends data, FIN and ignored packet events on the input stream and checks
// every acknowledgement beat against an in-bench model of the reorder window
// (cumulative ack, free window, merged SACK ranges, drops and FIN acks).
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sack_pkg::*;

  localparam int WIN      = 64;
  localparam int MAXB     = 4;
  localparam int SETTLE   = 2 * WIN;
  localparam int N_PHASES = 5;
  localparam int PER_PH   = 84;

  localparam logic [1:0] FUNC_OTHER = 2'd2;
  localparam logic [1:0] FUNC_RSVD  = 2'd3;

  typedef enum logic [1:0] {CHK_NONE, CHK_DATA, CHK_FIN} chk_e;

  typedef struct packed {
    logic [31:0] cum_ack;
    logic [15:0] avail;
    logic [4:0]  bcount;
    logic        bvalid;
    logic [31:0] bstart;
    logic [31:0] bend;
    logic [6:0]  released;
    logic        dropped;
    logic        is_fin;
    logic [31:0] fin_ack;
    logic        last;
  } ack_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] seq;
    chk_e        chk;
    logic [31:0] e_cum;
    logic [6:0]  e_rel;
    logic        e_drop;
    logic [31:0] e_fin;
  } row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [15:0]   cfg_wdata = '0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [1:0]    in_tuser = '0;     // func
  logic [31:0]   in_tdata = '0;     // seq
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic          out_tlast;
  logic [159:0]  out_tdata;         // cum_ack, avail_window, block_count, block_valid,
                                    // block_start, block_end, released_count,
                                    // dropped, is_fin_ack, fin_ack, pad

  // window state mirror
  logic [31:0]    next_seq;
  logic [WIN-1:0] held;
  int unsigned    held_cnt;
  logic           fin_done;
  logic [31:0]    fin_seq;
  logic [15:0]    rwin;

  ack_t pending_acks[$];
  int   errors, n_acks, n_fin, n_drop, n_ranges, n_items;
  bit   long_hold_req;

  sack_receive_reorder_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got 0x%08h expected 0x%08h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // work out the acknowledgement beats for one accepted packet event
  task automatic predict_acks(logic [1:0] func, logic [31:0] seq);
    logic [31:0] d, starts[MAXB], ends[MAXB];
    int unsigned rel, nb, i, j;
    logic drop;
    ack_t a;
    rel = 0; nb = 0; drop = 1'b0;
    a = '0;
    if (func == FUNC_FIN) begin
      if (!fin_done) begin
        fin_done = 1'b1;
        fin_seq  = seq;
      end
      a.cum_ack = next_seq - 32'd1;
      a.avail   = (rwin == 16'd0) ? 16'd1 : rwin;
      a.is_fin  = 1'b1;
      a.fin_ack = fin_seq + 32'd1;
      a.last    = 1'b1;
      pending_acks = {pending_acks, a};
      n_fin++;
      return;
    end
    if (func != FUNC_DATA || fin_done) return;
    if (seq >= next_seq) begin
      d = seq - next_seq;
      if (d >= WIN) begin
        drop = 1'b1;
      end else begin
        if (!held[d]) begin
          held[d] = 1'b1;
          held_cnt++;
        end
        while (held[0]) begin
          held = held >> 1;
          held_cnt--;
          next_seq++;
          rel++;
        end
      end
    end
    a.cum_ack  = next_seq - 32'd1;
    a.avail    = (rwin > held_cnt && rwin - held_cnt > 1) ? 16'(rwin - held_cnt) : 16'd1;
    a.released = (rel > 127) ? 7'd127 : 7'(rel);
    a.dropped  = drop;
    i = 1;
    while (i < WIN && nb < MAXB) begin
      if (!held[i]) begin
        i++;
      end else begin
        j = i;
        while (j + 1 < WIN && held[j+1]) j++;
        starts[nb] = next_seq + i;
        ends[nb]   = next_seq + j;
        nb++;
        i = j + 1;
      end
    end
    n_drop += drop;
    if (nb == 0) begin
      a.last = 1'b1;
      pending_acks = {pending_acks, a};
      return;
    end
    n_ranges += nb;
    for (int k = 0; k < nb; k++) begin
      a.bcount = 5'(nb);
      a.bvalid = 1'b1;
      a.bstart = starts[k];
      a.bend   = ends[k];
      a.last   = (k + 1 == nb);
      pending_acks = {pending_acks, a};
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_acks(in_tuser, in_tdata);
  end

  always @(posedge clk) begin
    ack_t g, w;
    if (rst_n && out_tvalid && out_tready) begin
      g = {out_tdata[31:0], out_tdata[47:32], out_tdata[52:48], out_tdata[53],
           out_tdata[85:54], out_tdata[117:86], out_tdata[124:118], out_tdata[125],
           out_tdata[126], out_tdata[158:127], out_tlast};
      n_acks++;
      if (pending_acks.size() == 0) begin
        $display("[%0t] unexpected acknowledgement beat", $realtime);
        errors++;
      end else begin
        w = pending_acks.pop_front();
        if (g.cum_ack  !== w.cum_ack)  report("cum_ack", g.cum_ack, w.cum_ack);
        if (g.avail    !== w.avail)    report("avail_window", g.avail, w.avail);
        if (g.bcount   !== w.bcount)   report("block_count", g.bcount, w.bcount);
        if (g.bvalid   !== w.bvalid)   report("block_valid", g.bvalid, w.bvalid);
        if (g.bstart   !== w.bstart)   report("block_start", g.bstart, w.bstart);
        if (g.bend     !== w.bend)     report("block_end", g.bend, w.bend);
        if (g.released !== w.released) report("released_count", g.released, w.released);
        if (g.dropped  !== w.dropped)  report("dropped", g.dropped, w.dropped);
        if (g.is_fin   !== w.is_fin)   report("is_fin_ack", g.is_fin, w.is_fin);
        if (g.fin_ack  !== w.fin_ack)  report("fin_ack", g.fin_ack, w.fin_ack);
        if (g.last     !== w.last)     report("tlast", g.last, w.last);
      end
    end
  end

  // receiver: random stalls, calm stretches, and one long hold-off on request
  initial begin
    int stall, calm;
    bit held_off;
    held_off = 1'b0;
    calm = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !held_off) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      if (calm > 0) begin
        calm--;
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        calm = $urandom_range(20, 80);
        out_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_pkt(logic [1:0] func, logic [31:0] seq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= seq;
    do @(posedge clk); while (!in_tready);
    if (func == FUNC_DATA || func == FUNC_FIN) n_items++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_acks.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rwin = v;
  endtask

  task automatic run_rows(const ref row_t rows[], input int first, input int stop);
    ack_t a;
    for (int r = first; r < stop; r++) begin
      send_pkt(rows[r].func, rows[r].seq);
      // typed-in values are checked against the newest predicted beat
      if (rows[r].chk != CHK_NONE) begin
        @(negedge clk);
        a = pending_acks[$];
        if (rows[r].chk == CHK_FIN) begin
          if (a.fin_ack !== rows[r].e_fin) report("typed fin_ack", a.fin_ack, rows[r].e_fin);
        end else begin
          if (a.cum_ack !== rows[r].e_cum) report("typed cum_ack", a.cum_ack, rows[r].e_cum);
          if (a.released !== rows[r].e_rel) report("typed released", a.released, rows[r].e_rel);
          if (a.dropped !== rows[r].e_drop) report("typed dropped", a.dropped, rows[r].e_drop);
        end
      end
    end
  endtask

  initial begin
    row_t rows[];
    logic [15:0] windows[N_PHASES];
    int r;
    logic [31:0] s;
    rows = '{
      '{FUNC_DATA, 32'd1,          CHK_DATA, 32'd1, 7'd1, 1'b0, 32'd0},
      '{FUNC_DATA, 32'd3,          CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd5,          CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd7,          CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd9,          CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd11,         CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd4,          CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd3,          CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd0,          CHK_DATA, 32'd1, 7'd0, 1'b0, 32'd0},
      '{FUNC_DATA, 32'd1,          CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd2,          CHK_DATA, 32'd5, 7'd4, 1'b0, 32'd0},
      '{FUNC_DATA, 32'd65,         CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd69,         CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd70,         CHK_DATA, 32'd5, 7'd0, 1'b1, 32'd0},
      '{FUNC_DATA, 32'hFFFF_FFFF,  CHK_DATA, 32'd5, 7'd0, 1'b1, 32'd0},
      '{FUNC_OTHER, 32'd0,         CHK_NONE, 0, 0, 0, 0},
      '{FUNC_RSVD, 32'hFFFF_FFFF,  CHK_NONE, 0, 0, 0, 0},
      '{FUNC_DATA, 32'd6,          CHK_NONE, 0, 0, 0, 0},
      // closing rows, after the random part: FIN ends data handling
      '{FUNC_FIN,  32'hFFFF_FFFF,  CHK_FIN, 0, 0, 0, 32'd0},
      '{FUNC_FIN,  32'd7,          CHK_FIN, 0, 0, 0, 32'd0},
      '{FUNC_DATA, 32'd0,          CHK_NONE, 0, 0, 0, 0},
      '{FUNC_RSVD, 32'd0,          CHK_NONE, 0, 0, 0, 0},
      '{FUNC_FIN,  32'h5555_AAAA,  CHK_FIN, 0, 0, 0, 32'd0}
    };
    windows = '{16'd65535, 16'd1, 16'd5, 16'($urandom_range(2, 65534)), 16'd64};
    next_seq = 32'd1; held = '0; held_cnt = 0;
    fin_done = 1'b0; fin_seq = '0; rwin = 16'd64;
    errors = 0; n_acks = 0; n_fin = 0; n_drop = 0; n_ranges = 0; n_items = 0;
    long_hold_req = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_window(16'd64);
    run_rows(rows, 0, 18);

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_window(windows[p]);
      if (p == 2) long_hold_req = 1'b1;
      for (int n = 0; n < PER_PH; n++) begin
        r = $urandom_range(0, 99);
        if (r < 40)      s = next_seq + $urandom_range(0, 3);
        else if (r < 80) s = next_seq + $urandom_range(4, WIN - 1);
        else if (r < 88) s = next_seq - $urandom_range(1, 40);
        else if (r < 92) s = next_seq + $urandom_range(WIN, WIN + 200);
        else if (r < 96) s = $urandom;
        else begin
          send_pkt(2'($urandom_range(FUNC_OTHER, FUNC_RSVD)), $urandom);
          continue;
        end
        send_pkt(FUNC_DATA, s);
      end
    end

    settle();
    run_rows(rows, 18, rows.size());
    settle();
    $display("Sent %0d data/FIN events; checked %0d ack beats (%0d SACK ranges, %0d drops,",
             n_items, n_acks, n_ranges, n_drop);
    $display("  %0d FIN acks) over %0d window settings.", n_fin, N_PHASES + 1);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sack_pkg.sv
rtl/core/sack_datapath.sv
rtl/core/sack_ctrl.sv
rtl/core/sack_receive_reorder_tracker.sv
sim/tb_top.sv
